FILE: rtl/pld_pkg.sv
// Shared constants for the point light distance attenuation pipeline.
`timescale 1ns / 1ps
package pld_pkg;
   localparam int OUT_FRAC_BITS = 16;

   localparam int COORD_W = 24;
   localparam int CFG_W   = 24;
   localparam int IDX_W   = 3;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int MAG_W   = COORD_W;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int D2_W    = SQ_W + 2;
   localparam int ROOT_W  = D2_W / 2;
   localparam int REM_W   = ROOT_W + 3;
   localparam int LINP_W  = CFG_W + ROOT_W;
   localparam int LIN_W   = LINP_W - 12;
   localparam int QH_W    = CFG_W + D2_W - 24;
   localparam int QL_W    = CFG_W + 24;
   localparam int QUAD_W  = QH_W + 1;
   localparam int SUM_W   = QUAD_W + 1;
   localparam int COEFF_W = 40;
   localparam int QUO_W   = OUT_FRAC_BITS + 1;
   localparam int ATT_W   = 17;

   localparam logic [COEFF_W-1:0] COEFF_MAX = {COEFF_W{1'b1}};
   localparam logic [COEFF_W-1:0] COEFF_ONE = COEFF_W'(65536);
   // The numerator 2^(16+F) shifted down by the quotient width.
   localparam logic [COEFF_W-1:0] DIV_INIT  = COEFF_W'(32768);

   localparam logic [IDX_W-1:0] CFG_LIGHT_X      = 3'd0;
   localparam logic [IDX_W-1:0] CFG_LIGHT_Y      = 3'd1;
   localparam logic [IDX_W-1:0] CFG_LIGHT_Z      = 3'd2;
   localparam logic [IDX_W-1:0] CFG_CONST_COEFF  = 3'd3;
   localparam logic [IDX_W-1:0] CFG_LINEAR_COEFF = 3'd4;
   localparam logic [IDX_W-1:0] CFG_QUAD_COEFF   = 3'd5;

   localparam logic [CFG_W-1:0] CONST_COEFF_RESET = CFG_W'(65536);

   // Pipeline stage positions.
   localparam int ST_SQRT = 3;
   localparam int ST_M1   = ST_SQRT + ROOT_W;
   localparam int ST_DIV  = ST_M1 + 3;
   localparam int NST     = ST_DIV + QUO_W;
endpackage

FILE: rtl/point_light_distance_attenuation.sv
// Point light distance attenuation: distance, quadratic falloff and reciprocal.
//
//   channel  ports                         moves
//   req      req_valid / req_ready         point_x, point_y, point_z (Q12.12)
//   rsp      rsp_valid / rsp_ready         attenuation (Q1.16)
//   csr      csr_write_enable              light position and coefficients
//
// One request enters per cycle while the pipe is not held. Each result passes
// through 3 stages of difference, square and sum, one stage per root bit of the
// square root, 3 stages of products and sum, and one per quotient bit.
// Reset clears the stage valid bits and loads the register defaults.
// When the last stage holds a result that is not taken, the whole pipe holds.
`timescale 1ns / 1ps
module point_light_distance_attenuation (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [pld_pkg::COORD_W-1:0]  req_point_x,
   input  logic signed [pld_pkg::COORD_W-1:0]  req_point_y,
   input  logic signed [pld_pkg::COORD_W-1:0]  req_point_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pld_pkg::ATT_W-1:0]           rsp_attenuation,
   input  logic                                csr_write_enable,
   input  logic [pld_pkg::IDX_W-1:0]           csr_index,
   input  logic [pld_pkg::CFG_W-1:0]           csr_write_data
);
   import pld_pkg::*;

   logic [CFG_W-1:0] light_x_ff, light_y_ff, light_z_ff;
   logic [CFG_W-1:0] kc_ff, kl_ff, kq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_x_ff <= '0;
         light_y_ff <= '0;
         light_z_ff <= '0;
         kc_ff      <= CONST_COEFF_RESET;
         kl_ff      <= '0;
         kq_ff      <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CFG_LIGHT_X:      light_x_ff <= csr_write_data;
            CFG_LIGHT_Y:      light_y_ff <= csr_write_data;
            CFG_LIGHT_Z:      light_z_ff <= csr_write_data;
            CFG_CONST_COEFF:  kc_ff      <= csr_write_data;
            CFG_LINEAR_COEFF: kl_ff      <= csr_write_data;
            CFG_QUAD_COEFF:   kq_ff      <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic           adv;
   logic [NST-1:0] vld_ff, vld_in;

   assign adv       = !vld_ff[NST-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[NST-1];
   assign vld_in    = {vld_ff[NST-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   function automatic logic [MAG_W-1:0] abs_diff(input logic [COORD_W-1:0] p,
                                                 input logic [COORD_W-1:0] l);
      logic signed [DIFF_W-1:0] d;
      logic signed [DIFF_W-1:0] n;
      d = $signed({p[COORD_W-1], p}) - $signed({l[COORD_W-1], l});
      n = -d;
      return d[DIFF_W-1] ? n[MAG_W-1:0] : d[MAG_W-1:0];
   endfunction

   // Stage 1 to 3: magnitudes, squares, squared distance.
   logic [MAG_W-1:0] mx_ff, my_ff, mz_ff;
   logic [SQ_W-1:0]  sx_ff, sy_ff, sz_ff;
   logic [D2_W-1:0]  d2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         mx_ff <= abs_diff(req_point_x, light_x_ff);
         my_ff <= abs_diff(req_point_y, light_y_ff);
         mz_ff <= abs_diff(req_point_z, light_z_ff);
         sx_ff <= mx_ff * mx_ff;
         sy_ff <= my_ff * my_ff;
         sz_ff <= mz_ff * mz_ff;
         d2_ff <= D2_W'(sx_ff) + D2_W'(sy_ff) + D2_W'(sz_ff);
      end
   end

   // Square root, one root bit per stage, two radicand bits consumed each.
   logic [REM_W-1:0]  rt_rem_ff  [0:ROOT_W-1];
   logic [ROOT_W-1:0] rt_root_ff [0:ROOT_W-1];
   logic [D2_W-1:0]   rt_d2_ff   [0:ROOT_W-1];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      localparam int I = ROOT_W - 1 - k;
      logic [REM_W-1:0]  rem_prev, rem_cat, trial, rem_in;
      logic [ROOT_W-1:0] root_prev, root_in;
      logic [D2_W-1:0]   d2_prev;
      logic              ge;
      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign d2_prev   = d2_ff;
      end else begin : g_next
         assign rem_prev  = rt_rem_ff[k-1];
         assign root_prev = rt_root_ff[k-1];
         assign d2_prev   = rt_d2_ff[k-1];
      end
      always_comb begin
         rem_cat = {rem_prev[REM_W-3:0], d2_prev[2*I+1 -: 2]};
         trial   = {1'b0, root_prev, 2'b01};
         ge      = rem_cat >= trial;
         rem_in  = ge ? rem_cat - trial : rem_cat;
         root_in = {root_prev[ROOT_W-2:0], ge};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rt_rem_ff[k]  <= rem_in;
            rt_root_ff[k] <= root_in;
            rt_d2_ff[k]   <= d2_prev;
         end
      end
   end

   // Products, then the partial sums, then the saturated coefficient.
   logic [LINP_W-1:0]  linp_ff;
   logic [QH_W-1:0]    qh_ff;
   logic [QL_W-1:0]    ql_ff;
   logic [LIN_W-1:0]   lin_ff;
   logic [QUAD_W-1:0]  quad_ff;
   logic [COEFF_W-1:0] den_ff;
   logic [D2_W-1:0]    d2_last;
   logic [SUM_W-1:0]   sum;
   logic [COEFF_W-1:0] coeff;

   assign d2_last = rt_d2_ff[ROOT_W-1];

   always_comb begin
      sum   = SUM_W'(kc_ff) + SUM_W'(lin_ff) + SUM_W'(quad_ff);
      coeff = (sum > SUM_W'(COEFF_MAX)) ? COEFF_MAX : sum[COEFF_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         linp_ff <= kl_ff * rt_root_ff[ROOT_W-1];
         qh_ff   <= kq_ff * d2_last[D2_W-1:24];
         ql_ff   <= kq_ff * d2_last[23:0];
         lin_ff  <= linp_ff[LINP_W-1:12];
         quad_ff <= QUAD_W'(qh_ff) + QUAD_W'(ql_ff[QL_W-1:24]);
         // A zero sum divides as one, which gives 1.0 as required.
         den_ff  <= (coeff < COEFF_ONE) ? COEFF_ONE : coeff;
      end
   end

   // Restoring division of 2^(16+F) by the denominator, one quotient bit a stage.
   logic [COEFF_W-1:0] dv_rem_ff [0:QUO_W-1];
   logic [COEFF_W-1:0] dv_den_ff [0:QUO_W-1];
   logic [QUO_W-1:0]   dv_quo_ff [0:QUO_W-1];

   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      logic [COEFF_W-1:0] rem_prev, den_prev, rem_in;
      logic [COEFF_W:0]   rem_sh;
      logic [QUO_W-1:0]   quo_prev, quo_in;
      logic               ge;
      if (j == 0) begin : g_first
         assign rem_prev = DIV_INIT;
         assign den_prev = den_ff;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = dv_rem_ff[j-1];
         assign den_prev = dv_den_ff[j-1];
         assign quo_prev = dv_quo_ff[j-1];
      end
      always_comb begin
         rem_sh = {rem_prev, 1'b0};
         ge     = rem_sh >= {1'b0, den_prev};
         rem_in = ge ? COEFF_W'(rem_sh - {1'b0, den_prev}) : rem_sh[COEFF_W-1:0];
         quo_in = {quo_prev[QUO_W-2:0], ge};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[j] <= rem_in;
            dv_den_ff[j] <= den_prev;
            dv_quo_ff[j] <= quo_in;
         end
      end
   end

   if (QUO_W >= ATT_W) begin : g_att_cut
      assign rsp_attenuation = dv_quo_ff[QUO_W-1][ATT_W-1:0];
   end else begin : g_att_ext
      assign rsp_attenuation = ATT_W'(dv_quo_ff[QUO_W-1]);
   end
endmodule

FILE: rtl/pld_checker.sv
// Port-level checks for the point light distance attenuation block.
`timescale 1ns / 1ps
module pld_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [pld_pkg::ATT_W-1:0]   rsp_attenuation
);
   import pld_pkg::*;

   localparam logic [ATT_W:0] ATT_ONE = (ATT_W + 1)'(1) << OUT_FRAC_BITS;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_attenuation))
      else $error("stalled result changed or dropped");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused while the output is empty");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (OUT_FRAC_BITS > 16) || ({1'b0, rsp_attenuation} <= ATT_ONE))
      else $error("attenuation above one");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
endmodule

bind point_light_distance_attenuation pld_checker u_pld_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_attenuation (rsp_attenuation)
);
